// ===== rtl/core/sentence_field_window_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// sentence field window extractor: assertion macros
// shared assertion forms, sampled on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SENTENCE_FIELD_WINDOW_EXTRACTOR_MACROS_SVH
`define SENTENCE_FIELD_WINDOW_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define SFWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfwe assertion failed");

// next-cycle implication
`define SFWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfwe assertion failed");

`endif

// ===== rtl/core/sfwe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfwe_pkg
// constants shared by the sentence field window extractor
// ----------------------------------------------------------------------------
`default_nettype none

package sfwe_pkg;

  localparam int MAX_HEADER = 8;
  localparam int HDR_W      = 8 * MAX_HEADER;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEADER_TEXT    = 2'd0,
    CFG_HEADER_LENGTH  = 2'd1,
    CFG_SEPARATOR_CHAR = 2'd2,
    CFG_FIELD_COUNT    = 2'd3
  } cfg_idx_t;

  localparam logic [HDR_W-1:0] HEADER_TEXT_RST    = 64'd92738097136676;
  localparam logic [LEN_W-1:0] HEADER_LENGTH_RST  = 4'd6;
  localparam logic [7:0]       SEPARATOR_CHAR_RST = 8'd44;
  localparam logic [7:0]       FIELD_COUNT_RST    = 8'd6;

endpackage

`default_nettype wire

// ===== rtl/core/sentence_field_window_extractor.sv =====
// ----------------------------------------------------------------------------
// sentence_field_window_extractor
// finds a configured header in a byte frame, skips one byte, then passes on
// the first field_count fields with the final byte flagged
// ----------------------------------------------------------------------------
//  channel  ports                                         direction
//  in       in_valid in_stall in_data_byte in_end_of_frame  sink
//  out      out_valid out_stall out_byte out_last ...       source
//  cfg      cfg_we cfg_index cfg_data                       sink, write only
//
//  one byte a cycle while in_stall is low: each byte is handled in the cycle
//  it is taken; any result lands in the output register at that edge
//  each byte is held back one item so the final one can carry out_last
//  in_stall rises only while a result waits in the output register under
//  out_stall; reset is synchronous and returns the frame state to idle
// ----------------------------------------------------------------------------
`default_nettype none

module sentence_field_window_extractor
  import sfwe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_end_of_frame,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  out_empty_res,
  output logic                  out_error,
  // configuration
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [HDR_W-1:0] cfg_data
);

`include "sentence_field_window_extractor_macros.svh"

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_SKIP    = 2'd1,
    PH_EXTRACT = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // configuration registers
  logic [HDR_W-1:0] header_text_r;
  logic [LEN_W-1:0] header_length_r;
  logic [7:0]       separator_char_r;
  logic [7:0]       field_count_r;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic [HDR_W-1:0] recent_r, recent_nxt;
  logic [CNT_W-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0]       sep_seen_r, sep_seen_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt;
  logic             pend_valid_r, pend_valid_nxt;

  // output register
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_empty_r;
  logic             out_error_r;

  logic             in_accept;
  logic [LEN_W-1:0] hdr_len;
  logic [HDR_W-1:0] window;
  logic [CNT_W-1:0] count_inc;
  logic             hdr_hit;
  logic             is_sep;
  logic             closing;

  logic             res_vld;
  logic [7:0]       res_byte;
  logic             res_last;
  logic             res_empty;
  logic             res_err;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign hdr_len   = (header_length_r > LEN_W'(MAX_HEADER)) ? LEN_W'(MAX_HEADER)
                                                            : header_length_r;
  assign window    = {in_data_byte, recent_r[HDR_W-1:8]};
  assign count_inc = (bytes_seen_r < CNT_W'(MAX_HEADER)) ? bytes_seen_r + 1'b1
                                                          : bytes_seen_r;

  sfwe_header_match u_match (
    .window      (window),
    .count       (count_inc),
    .header_text (header_text_r),
    .header_len  (hdr_len),
    .hit         (hdr_hit)
  );

  assign is_sep  = (in_data_byte == separator_char_r);
  assign closing = is_sep && (field_count_r != 8'd0) &&
                   ((sep_seen_r + 8'd1) == field_count_r);

  always_comb begin
    phase_nxt      = phase_r;
    recent_nxt     = recent_r;
    bytes_seen_nxt = bytes_seen_r;
    sep_seen_nxt   = sep_seen_r;
    pend_byte_nxt  = pend_byte_r;
    pend_valid_nxt = pend_valid_r;
    res_vld        = 1'b0;
    res_byte       = 8'd0;
    res_last       = 1'b0;
    res_empty      = 1'b0;
    res_err        = 1'b0;

    unique case (phase_r)
      PH_SEEK: begin
        if (hdr_len == '0) begin
          phase_nxt = PH_EXTRACT;
        end else begin
          recent_nxt     = window;
          bytes_seen_nxt = count_inc;
          if (hdr_hit) begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_EXTRACT;
      end
      PH_EXTRACT: begin
        if (closing) begin
          // final separator: flush the held byte as the last one
          res_vld        = 1'b1;
          res_last       = 1'b1;
          res_byte       = pend_valid_r ? pend_byte_r : 8'd0;
          res_empty      = !pend_valid_r;
          pend_valid_nxt = 1'b0;
          pend_byte_nxt  = 8'd0;
          phase_nxt      = PH_DONE;
        end else if (!in_end_of_frame) begin
          if (is_sep) begin
            sep_seen_nxt = sep_seen_r + 8'd1;
          end
          res_vld        = pend_valid_r;
          res_byte       = pend_byte_r;
          pend_byte_nxt  = in_data_byte;
          pend_valid_nxt = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (in_end_of_frame) begin
      if (phase_nxt != PH_DONE) begin
        res_vld   = 1'b1;
        res_byte  = 8'd0;
        res_last  = 1'b1;
        res_empty = 1'b0;
        res_err   = 1'b1;
      end
      phase_nxt      = PH_SEEK;
      recent_nxt     = '0;
      bytes_seen_nxt = '0;
      sep_seen_nxt   = '0;
      pend_byte_nxt  = '0;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_text_r    <= HEADER_TEXT_RST;
      header_length_r  <= HEADER_LENGTH_RST;
      separator_char_r <= SEPARATOR_CHAR_RST;
      field_count_r    <= FIELD_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEADER_TEXT:    header_text_r    <= cfg_data;
        CFG_HEADER_LENGTH:  header_length_r  <= cfg_data[LEN_W-1:0];
        CFG_SEPARATOR_CHAR: separator_char_r <= cfg_data[7:0];
        CFG_FIELD_COUNT:    field_count_r    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEEK;
      recent_r     <= '0;
      bytes_seen_r <= '0;
      sep_seen_r   <= '0;
      pend_byte_r  <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r      <= phase_nxt;
        recent_r     <= recent_nxt;
        bytes_seen_r <= bytes_seen_nxt;
        sep_seen_r   <= sep_seen_nxt;
        pend_byte_r  <= pend_byte_nxt;
        pend_valid_r <= pend_valid_nxt;
      end
      if (in_accept && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (in_accept && res_vld) begin
      out_byte_r  <= res_byte;
      out_last_r  <= res_last;
      out_empty_r <= res_empty;
      out_error_r <= res_err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;
  assign out_error     = out_error_r;

  `SFWE_ASSERT_IMP(a_err_shape, out_valid_r && out_error_r,
                   out_last_r && !out_empty_r && (out_byte_r == 8'd0))
  `SFWE_ASSERT_IMP(a_empty_shape, out_valid_r && out_empty_r,
                   out_last_r && !out_error_r && (out_byte_r == 8'd0))
  `SFWE_ASSERT_IMP(a_pend_in_extract, pend_valid_r, phase_r == PH_EXTRACT)
  `SFWE_ASSERT_NEXT(a_eof_clears, in_accept && in_end_of_frame,
                    (phase_r == PH_SEEK) && !pend_valid_r && (bytes_seen_r == '0))

endmodule

`default_nettype wire

// ===== rtl/core/sfwe_header_match.sv =====
// ----------------------------------------------------------------------------
// sfwe_header_match
// compares the newest header_len bytes of the window with the header text
// ----------------------------------------------------------------------------
`default_nettype none

module sfwe_header_match
  import sfwe_pkg::*;
(
  input  wire logic [HDR_W-1:0] window,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [HDR_W-1:0] header_text,
  input  wire logic [LEN_W-1:0] header_len,
  output logic                  hit
);

  logic [HDR_W-1:0] mask;
  logic [LEN_W-1:0] gap;
  logic [5:0]       shamt;
  logic [HDR_W-1:0] tail;

  // newest byte sits at the top, so the tail is shifted down by the unused bytes
  assign gap   = LEN_W'(MAX_HEADER) - header_len;
  assign shamt = {gap[2:0], 3'b000};
  assign tail  = window >> shamt;

  always_comb begin
    for (int k = 0; k < MAX_HEADER; k++) begin
      mask[8*k +: 8] = (LEN_W'(k) < header_len) ? 8'hFF : 8'h00;
    end
  end

  assign hit = (count >= header_len) && ((tail & mask) == (header_text & mask));

endmodule

`default_nettype wire

// ===== sim/field_window_checker.sv =====
// ----------------------------------------------------------------------------
// field window checker
// watches the byte, result and register ports of the extractor, works out the
// result each taken byte should give and compares every result taken
// ----------------------------------------------------------------------------
module field_window_checker
  import sfwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_frame,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [7:0]       out_byte,
  input  logic             out_last,
  input  logic             out_empty_res,
  input  logic             out_error,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [HDR_W-1:0] cfg_data,
  output int unsigned      mismatches,
  output int unsigned      awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SEEK_HDR, SKIP_ONE, COPY, DONE} scan_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic       err;
  } span_out_t;

  logic [HDR_W-1:0] hdr_text;
  logic [LEN_W-1:0] hdr_len;
  logic [7:0]       sep_char;
  logic [7:0]       fld_count;

  logic [63:0]      window;
  scan_phase_t      phase;
  logic [7:0]       seps;
  logic [7:0]       held;
  logic             held_ok;
  logic [3:0]       seen;

  span_out_t        span_q[$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  task automatic clear_frame();
    window  = '0;
    phase   = SEEK_HDR;
    seps    = '0;
    held    = '0;
    held_ok = 1'b0;
    seen    = '0;
  endtask

  task automatic extract_byte(input logic [7:0] b, input logic eof);
    int unsigned len;
    logic [63:0] mask;
    logic [63:0] tail;
    span_out_t   res;
    bit          got;
    got = 0;
    res = '0;
    len = (hdr_len > MAX_HEADER) ? MAX_HEADER : hdr_len;
    case (phase)
      SEEK_HDR: begin
        if (len == 0) begin
          // empty header matches at once, this byte is the skipped one
          phase = COPY;
        end else begin
          window = {b, window[63:8]};
          if (seen < MAX_HEADER) seen++;
          mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
          tail = window >> (64 - 8 * len);
          if (seen >= len && tail == (hdr_text & mask)) phase = SKIP_ONE;
        end
      end
      SKIP_ONE: phase = COPY;
      COPY: begin
        if (b == sep_char && fld_count != 0 && 8'(seps + 8'd1) == fld_count) begin
          res     = held_ok ? {held, 1'b1, 1'b0, 1'b0} : {8'h00, 1'b1, 1'b1, 1'b0};
          got     = 1;
          held_ok = 1'b0;
          held    = '0;
          phase   = DONE;
        end else if (!eof) begin
          if (b == sep_char) seps++;
          if (held_ok) begin
            res = {held, 1'b0, 1'b0, 1'b0};
            got = 1;
          end
          held    = b;
          held_ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (phase != DONE) begin
        res = {8'h00, 1'b1, 1'b0, 1'b1};
        got = 1;
      end
      clear_frame();
    end
    if (got) span_q.push_back(res);
  endtask

  always @(posedge clk) begin
    span_out_t want;
    if (!rst_n) begin
      hdr_text  = HEADER_TEXT_RST;
      hdr_len   = HEADER_LENGTH_RST;
      sep_char  = SEPARATOR_CHAR_RST;
      fld_count = FIELD_COUNT_RST;
      clear_frame();
      span_q.delete();
    end else begin
      // a result taken now came from a byte taken at an earlier edge
      if (out_valid && !out_stall) begin
        if (span_q.size() == 0) begin
          mismatches++;
          $error("unexpected result: out_byte 0x%02h last %0b empty_res %0b error %0b",
                 out_byte, out_last, out_empty_res, out_error);
        end else begin
          want = span_q.pop_front();
          if (out_byte !== want.ch) begin
            mismatches++;
            $error("out_byte: expected 0x%02h, got 0x%02h", want.ch, out_byte);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $error("out_last: expected %0b, got %0b", want.last, out_last);
          end
          if (out_empty_res !== want.empty) begin
            mismatches++;
            $error("out_empty_res: expected %0b, got %0b", want.empty, out_empty_res);
          end
          if (out_error !== want.err) begin
            mismatches++;
            $error("out_error: expected %0b, got %0b", want.err, out_error);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_TEXT:    hdr_text  = cfg_data;
          CFG_HEADER_LENGTH:  hdr_len   = cfg_data[LEN_W-1:0];
          CFG_SEPARATOR_CHAR: sep_char  = cfg_data[7:0];
          CFG_FIELD_COUNT:    fld_count = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) extract_byte(in_data_byte, in_end_of_frame);
    end
    awaiting = span_q.size();
  end

endmodule

// ===== sim/sentence_field_window_extractor_test.sv =====
// ----------------------------------------------------------------------------
// sentence field window extractor test
// feeds byte frames (fixed cases, then random well-formed and broken frames
// under several register settings) with random gaps and result stalls; the
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module sentence_field_window_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfwe_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = '0;
  logic             in_end_of_frame = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_empty_res;
  logic             out_error;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_HEADER_TEXT;
  logic [HDR_W-1:0] cfg_data = '0;

  int unsigned      mismatches;
  int unsigned      awaiting;

  // copy of the register settings, used to build frames that match them
  logic [HDR_W-1:0] hdr_text_set = HEADER_TEXT_RST;
  logic [LEN_W-1:0] hdr_len_set  = HEADER_LENGTH_RST;
  logic [7:0]       sep_set      = SEPARATOR_CHAR_RST;
  logic [7:0]       count_set    = FIELD_COUNT_RST;

  int unsigned      gap_pct   = 7;
  int unsigned      stall_pct = 82;
  int unsigned      bytes_fed = 0;
  int unsigned      frame_no  = 0;
  int unsigned      target;
  int               hdr_pos;
  logic [7:0]       frame_q[$];

  sentence_field_window_extractor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_empty_res   (out_empty_res),
    .out_error       (out_error),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  field_window_checker watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_empty_res   (out_empty_res),
    .out_error       (out_error),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting)
  );

  always #6 clk = ~clk;

  initial begin
    #5ms;
    $display("[sentence_field_window_extractor] ERROR");
    $finish;
  end

  // result side stalls at random
  initial forever begin
    @(negedge clk);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // entered and left at a falling edge; valid stays high into the next item
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_stall);
    bytes_fed++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (awaiting == 0);
    // a byte may still be held inside the block with no result due yet
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [HDR_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_TEXT:    hdr_text_set = val;
      CFG_HEADER_LENGTH:  hdr_len_set  = val[LEN_W-1:0];
      CFG_SEPARATOR_CHAR: sep_set      = val[7:0];
      CFG_FIELD_COUNT:    count_set    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic play_frame(input bit close);
    for (int i = 0; i < frame_q.size(); i++)
      push_byte(frame_q[i], close && (i == frame_q.size() - 1));
  endtask

  task automatic feed_text(input string s, input bit close);
    frame_q.delete();
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    play_frame(close);
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == sep_set);
    return c;
  endfunction

  // noise, header, skipped byte, the fields with their separators, then junk
  task automatic compose_frame(input int max_chars);
    int eff_len;
    int n_fields;
    frame_q.delete();
    eff_len  = (hdr_len_set > MAX_HEADER) ? MAX_HEADER : hdr_len_set;
    n_fields = (count_set == 0) ? 3 : count_set;
    repeat ($urandom_range(3)) frame_q.push_back(8'($urandom));
    hdr_pos = frame_q.size();
    for (int i = 0; i < eff_len; i++) frame_q.push_back(hdr_text_set[8*i +: 8]);
    frame_q.push_back(8'($urandom));
    for (int f = 0; f < n_fields; f++) begin
      repeat ($urandom_range(max_chars)) frame_q.push_back(field_char());
      frame_q.push_back(sep_set);
    end
    repeat ($urandom_range(3)) frame_q.push_back(8'($urandom));
  endtask

  task automatic random_frame();
    int kind;
    int eff_len;
    kind    = $urandom_range(99);
    eff_len = (hdr_len_set > MAX_HEADER) ? MAX_HEADER : hdr_len_set;
    if (kind < 10) begin
      frame_q.delete();
      repeat ($urandom_range(12, 1)) frame_q.push_back(8'($urandom));
    end else begin
      compose_frame((count_set > 20) ? 1 : 4);
      if (kind < 25) begin
        frame_q = frame_q[0:$urandom_range(frame_q.size() - 1)];
      end else if (kind < 32 && eff_len > 0) begin
        // one header character off by a bit
        frame_q[hdr_pos + $urandom_range(eff_len - 1)] ^= 8'(1 << $urandom_range(7));
      end
    end
    play_frame(1'b1);
  endtask

  task automatic shuffle_config();
    int r;
    write_reg(CFG_HEADER_TEXT, {$urandom, $urandom});
    r = $urandom_range(99);
    write_reg(CFG_HEADER_LENGTH, (r < 88) ? $urandom_range(8, 1) : $urandom_range(15));
    r = $urandom_range(99);
    write_reg(CFG_SEPARATOR_CHAR, (r < 40) ? 8'd44 : $urandom_range(255));
    r = $urandom_range(99);
    write_reg(CFG_FIELD_COUNT,
              (r < 80) ? $urandom_range(6, 1) : (r < 95) ? $urandom_range(24, 7) : 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fixed cases under the reset settings
    feed_text("$DVEXT,a,bb,,c,d,e,f*7A", 1);
    feed_text("xx$DVEX", 1);
    feed_text("$DVEXT", 1);
    feed_text("$DVEXT,a,b", 1);
    feed_text("$DVEXT,a,b,c,d,e,f,", 1);
    feed_text("$DVEXT,", 0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    feed_text(",1,2,3,4,5,", 1);

    // field count changed part way through a frame, after results drain
    feed_text("$DVEXT,a,b", 0);
    write_reg(CFG_FIELD_COUNT, 3);
    feed_text(",c,d,e,f", 1);

    // empty span
    write_reg(CFG_FIELD_COUNT, 1);
    feed_text("$DVEXT,,tail", 1);

    // empty header: first byte is skipped
    write_reg(CFG_HEADER_LENGTH, 0);
    feed_text("Zab,c", 1);

    // oversized length acts as full width
    write_reg(CFG_HEADER_TEXT, '1);
    write_reg(CFG_HEADER_LENGTH, 15);
    compose_frame(2);
    play_frame(1'b1);

    write_reg(CFG_HEADER_TEXT, '0);
    write_reg(CFG_HEADER_LENGTH, 1);
    write_reg(CFG_SEPARATOR_CHAR, 8'h00);
    compose_frame(3);
    play_frame(1'b1);

    // zero field count never completes
    write_reg(CFG_SEPARATOR_CHAR, 8'hFF);
    write_reg(CFG_FIELD_COUNT, 0);
    compose_frame(2);
    play_frame(1'b1);

    write_reg(CFG_HEADER_TEXT, {$urandom, $urandom});
    write_reg(CFG_HEADER_LENGTH, 8);
    write_reg(CFG_SEPARATOR_CHAR, 8'd44);
    write_reg(CFG_FIELD_COUNT, 255);
    compose_frame(0);
    play_frame(1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 7 : (ph == 1) ? 82 : 0;
      stall_pct = (ph == 0) ? 82 : (ph == 1) ? 7 : 0;
      target    = bytes_fed + 650;
      while (bytes_fed < target) begin
        if (frame_no % 6 == 0) shuffle_config();
        random_frame();
        frame_no++;
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("[sentence_field_window_extractor] OK");
    end else begin
      $display("[sentence_field_window_extractor] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sfwe_pkg.sv
rtl/core/sfwe_header_match.sv
rtl/core/sentence_field_window_extractor.sv
sim/field_window_checker.sv
sim/sentence_field_window_extractor_test.sv
